[rtl/core/lbp_pkg.sv]
package lbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int PIX_W     = 8;
    localparam int CODE_W    = 8;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [SIZE_W-1:0]    size_t;
    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [COL_W-1:0]     col_t;

    // register indexes of the configuration port
    localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);

    // window[row][col]: row 0 is two rows up, col 0 is two columns left
    typedef pix_t [2:0]    pix_column_t;
    typedef pix_column_t [2:0] window_t;

    // one classified pixel: the 3x3 window ending at (row, col)
    typedef struct packed {
        window_t win;
        row_t    row;
        col_t    col;
        logic    last_row;
        logic    last_col;
        logic    row_ge2;
        logic    col_ge2;
    } job_t;

    // index of the last column, size clamped to 2..MAX_WIDTH
    function automatic col_t width_last(size_t v);
        size_t t;
        t = v - size_t'(1);
        if (v < size_t'(2))
            return col_t'(1);
        else if (32'(v) > MAX_WIDTH)
            return col_t'(MAX_WIDTH - 1);
        else
            return col_t'(t);
    endfunction

    // index of the last row, size clamped to 2..MAX_HEIGHT
    function automatic row_t height_last(size_t v);
        size_t t;
        t = v - size_t'(1);
        if (v < size_t'(2))
            return row_t'(1);
        else if (32'(v) > MAX_HEIGHT)
            return row_t'(MAX_HEIGHT - 1);
        else
            return row_t'(t);
    endfunction

endpackage

[rtl/core/lbp_front.sv]
module lbp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lbp_pkg::pix_t     pixel,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  lbp_pkg::cfg_idx_t cfg_index,
    input  lbp_pkg::size_t    cfg_data,
    output lbp_pkg::job_t     job,
    output logic              job_push,
    input  logic              job_full
);
    import lbp_pkg::*;

    size_t frame_width_reg;
    size_t frame_height_reg;
    row_t  row_count_reg, row_count_next;
    col_t  col_count_reg, col_count_next;

    // two line buffers: previous row and the row before it
    pix_t lb_a [MAX_WIDTH];
    pix_t lb_b [MAX_WIDTH];

    logic  s1_valid_reg;
    pix_t  s1_pix_reg;
    row_t  s1_row_reg;
    col_t  s1_col_reg;
    logic  s1_last_row_reg;
    logic  s1_last_col_reg;
    pix_t  rd_a_reg;
    pix_t  rd_b_reg;

    pix_column_t col1_reg;
    pix_column_t col0_reg;

    col_t  w_last;
    row_t  h_last;
    logic  accept;
    logic  cfg_hit;
    logic  s1_emit;
    logic  s1_adv;
    logic  at_last_col;
    logic  at_last_row;

    assign w_last      = width_last(frame_width_reg);
    assign h_last      = height_last(frame_height_reg);
    assign at_last_col = (col_count_reg == w_last);
    assign at_last_row = (row_count_reg == h_last);

    assign cfg_ready = 1'b1;
    assign cfg_hit   = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT);

    assign s1_emit  = (s1_row_reg != row_t'(0)) && (s1_col_reg != col_t'(0));
    assign s1_adv   = s1_valid_reg && !(s1_emit && job_full);
    assign full     = s1_valid_reg && s1_emit && job_full;
    assign accept   = push && !full;
    assign job_push = s1_adv && s1_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= size_t'(640);
            frame_height_reg <= size_t'(480);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_valid && cfg_hit)
        begin
            row_count_next = row_t'(0);
            col_count_next = col_t'(0);
        end
        else if (accept)
        begin
            if (at_last_col)
            begin
                col_count_next = col_t'(0);
                row_count_next = at_last_row ? row_t'(0) : row_count_reg + row_t'(1);
            end
            else
            begin
                col_count_next = col_count_reg + col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= row_t'(0);
            col_count_reg <= col_t'(0);
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    // read both line buffers at the incoming column, newest row into lb_a
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lb_a[col_count_reg] <= pixel;
            rd_a_reg            <= lb_a[col_count_reg];
            rd_b_reg            <= lb_b[col_count_reg];
            s1_pix_reg          <= pixel;
            s1_row_reg          <= row_count_reg;
            s1_col_reg          <= col_count_reg;
            s1_last_row_reg     <= at_last_row;
            s1_last_col_reg     <= at_last_col;
        end
    end

    // previous row moves down to the older buffer, window slides one column
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            lb_b[s1_col_reg] <= rd_a_reg;
            col0_reg         <= col1_reg;
            col1_reg         <= {s1_pix_reg, rd_a_reg, rd_b_reg};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job.win[i][0] = col0_reg[i];
            job.win[i][1] = col1_reg[i];
        end
        job.win[0][2] = rd_b_reg;
        job.win[1][2] = rd_a_reg;
        job.win[2][2] = s1_pix_reg;
        job.row       = s1_row_reg;
        job.col       = s1_col_reg;
        job.last_row  = s1_last_row_reg;
        job.last_col  = s1_last_col_reg;
        job.row_ge2   = (s1_row_reg >= row_t'(2));
        job.col_ge2   = (s1_col_reg >= col_t'(2));
    end

endmodule

[rtl/core/lbp_jobq.sv]
module lbp_jobq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lbp_pkg::job_t wr_job,
    output logic          q_full,
    input  logic          rd_en,
    output lbp_pkg::job_t rd_job,
    output logic          q_empty
);
    import lbp_pkg::*;

    typedef logic [JOBQ_PTR_W-1:0] ptr_t;
    typedef logic [JOBQ_PTR_W:0]   cnt_t;

    job_t entry_reg [JOBQ_DEPTH];
    ptr_t wr_ptr_reg;
    ptr_t rd_ptr_reg;
    cnt_t count_reg;

    assign q_full  = (count_reg == cnt_t'(JOBQ_DEPTH));
    assign q_empty = (count_reg == cnt_t'(0));
    assign rd_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= ptr_t'(0);
            rd_ptr_reg <= ptr_t'(0);
            count_reg  <= cnt_t'(0);
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == ptr_t'(JOBQ_DEPTH - 1)) ? ptr_t'(0)
                                                                    : wr_ptr_reg + ptr_t'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == ptr_t'(JOBQ_DEPTH - 1)) ? ptr_t'(0)
                                                                    : rd_ptr_reg + ptr_t'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + cnt_t'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - cnt_t'(1);
        end
    end

endmodule

[rtl/core/lbp_back.sv]
module lbp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lbp_pkg::job_t               job,
    input  logic                        job_empty,
    output logic                        job_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [lbp_pkg::CODE_W-1:0]  pattern_code,
    output lbp_pkg::row_t               center_row,
    output lbp_pkg::col_t               center_col,
    output logic                        run_last,
    output logic                        frame_end
);
    import lbp_pkg::*;

    // result kinds of one job, in emission order
    localparam int RES_CENTER = 0;
    localparam int RES_RIGHT  = 1;
    localparam int RES_BELOW  = 2;
    localparam int RES_CORNER = 3;

    logic [3:0] done_reg;
    logic       out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    row_t       row_reg;
    col_t       col_reg;
    logic       last_reg;
    logic       fend_reg;

    logic [3:0] want;
    logic [3:0] pending;
    logic [3:0] sel;
    logic [3:0] rest;
    logic       is_last;
    logic       load;
    logic       ri2;
    logic       ci2;
    logic [CODE_W-1:0] code;
    row_t       c_row;
    col_t       c_col;

    function automatic logic [CODE_W-1:0] lbp_code(window_t w, logic down, logic right,
                                                   logic row_ge2, logic col_ge2);
        logic [1:0] ru, rm, cl, cm;
        logic       up_ok, dn_ok, lf_ok, rt_ok;
        pix_t       ctr;
        logic [CODE_W-1:0] n;
        ru    = down  ? 2'd1 : 2'd0;
        rm    = down  ? 2'd2 : 2'd1;
        cl    = right ? 2'd1 : 2'd0;
        cm    = right ? 2'd2 : 2'd1;
        up_ok = down | row_ge2;
        dn_ok = !down;
        lf_ok = right | col_ge2;
        rt_ok = !right;
        ctr   = w[rm][cm];
        n[7]  = lf_ok && (w[rm][cl] >= ctr);
        n[6]  = dn_ok && lf_ok && (w[2][cl] >= ctr);
        n[5]  = dn_ok && (w[2][cm] >= ctr);
        n[4]  = dn_ok && rt_ok && (w[2][2] >= ctr);
        n[3]  = rt_ok && (w[rm][2] >= ctr);
        n[2]  = up_ok && rt_ok && (w[ru][2] >= ctr);
        n[1]  = up_ok && (w[ru][cm] >= ctr);
        n[0]  = up_ok && lf_ok && (w[ru][cl] >= ctr);
        return n;
    endfunction

    always_comb
    begin
        want             = '0;
        want[RES_CENTER] = 1'b1;
        want[RES_RIGHT]  = job.last_col;
        want[RES_BELOW]  = job.last_row;
        want[RES_CORNER] = job.last_row && job.last_col;
        pending          = want & ~done_reg;
        sel              = pending & (~pending + 4'd1);
        rest             = pending & ~sel;
        is_last          = (rest == 4'd0);
        ri2              = sel[RES_BELOW] | sel[RES_CORNER];
        ci2              = sel[RES_RIGHT] | sel[RES_CORNER];
        c_row            = ri2 ? job.row : job.row - row_t'(1);
        c_col            = ci2 ? job.col : job.col - col_t'(1);
        code             = lbp_code(job.win, ri2, ci2, job.row_ge2, job.col_ge2);
    end

    assign load    = !job_empty && (!out_valid_reg || pop);
    assign job_pop = load && is_last;
    assign empty   = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= 4'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                done_reg      <= is_last ? 4'd0 : (done_reg | sel);
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= code;
            row_reg  <= c_row;
            col_reg  <= c_col;
            last_reg <= is_last;
            fend_reg <= sel[RES_CORNER];
        end
    end

    assign pattern_code = code_reg;
    assign center_row   = row_reg;
    assign center_col   = col_reg;
    assign run_last     = last_reg;
    assign frame_end    = fend_reg;

endmodule

[rtl/core/lbp_3x3_stream.sv]
// channel   direction  handshake                 payload
// pixels    in         push / full               pixel
// results   out        empty / pop               pattern_code, center_row, center_col,
//                                                run_last, frame_end
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one pixel per cycle is taken while full is low; a pixel's first result reaches
// the result ports through the s1 registers, the job queue and the output register
// results leave through a single output register, one per cycle unless pop
// stalls: the last column gives two results and the last row two per pixel,
// so on the last row pixels arrive faster than results leave and full rises
// reset clears the counters, pipeline and queue; line buffers are not cleared,
// and their stale contents reach only window positions that the code masks off
// a stall on the result side fills the job queue and then raises full

module lbp_3x3_stream (
    input  logic                        clk,
    input  logic                        rst_n,
    // pixel input
    input  logic                        push,
    output logic                        full,
    input  lbp_pkg::pix_t               pixel,
    // result output
    output logic                        empty,
    input  logic                        pop,
    output logic [lbp_pkg::CODE_W-1:0]  pattern_code,
    output lbp_pkg::row_t               center_row,
    output lbp_pkg::col_t               center_col,
    output logic                        run_last,
    output logic                        frame_end,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  lbp_pkg::cfg_idx_t           cfg_index,
    input  lbp_pkg::size_t              cfg_data
);
    import lbp_pkg::*;

    job_t  fr_job;
    job_t  q_head;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    // front: position tracking, line buffers, 3x3 window assembly
    lbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job       (fr_job),
        .job_push  (q_push),
        .job_full  (q_full)
    );

    // short job queue decouples window building from result emission
    lbp_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (fr_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (q_head),
        .q_empty (q_empty)
    );

    // back: expands each job into one to four codes, one per cycle unless the result side stalls
    lbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (q_head),
        .job_empty    (q_empty),
        .job_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .pattern_code (pattern_code),
        .center_row   (center_row),
        .center_col   (center_col),
        .run_last     (run_last),
        .frame_end    (frame_end)
    );

    // bottom-right center is always the last result of its pixel
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> run_last)
        else $error("frame_end without run_last");

    // the front never writes a full job queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job queue overflow");

    // retiring a job always leaves a result in the output register
    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !empty)
        else $error("job retired without a result");

endmodule
